[design/dgt_pkg.sv]
// ----------------------------------------------------------------------------
// dgt_pkg
// Shared sizes, codes, types and helpers of the depth grid triangulator.
// ----------------------------------------------------------------------------
package dgt_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int SIZE_W  = 11;   // frame size registers
   localparam int COORD_W = 10;   // column, row and vertex coordinates
   localparam int IDX_W   = 20;   // vertex index
   localparam int DEPTH_W = 32;   // Q16.16 depth
   localparam int GREY_W  = 8;

   localparam int RAM_ADDR_W = $clog2(MAX_WIDTH);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes of the csr port
   localparam int                CSR_INDEX_W      = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);
   localparam logic [SIZE_W-1:0] MAX_W_SIZE   = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_H_SIZE   = SIZE_W'(MAX_HEIGHT);

   // result kinds
   localparam logic ITEM_VERTEX   = 1'b0;
   localparam logic ITEM_TRIANGLE = 1'b1;

   // one line buffer entry: flag and vertex index
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
   } dgt_entry_type;

   localparam int ENTRY_W = $bits(dgt_entry_type);

   // one classified pixel handed from the front to the back
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DEPTH_W-1:0] z;
      logic [GREY_W-1:0]  grey;
      logic [IDX_W-1:0]   cur_idx;
      logic [IDX_W-1:0]   ul_idx;
      logic [IDX_W-1:0]   left_idx;
      logic [IDX_W-1:0]   above_idx;
      logic               tri_a;     // (tl,bl,br)
      logic               tri_b;     // (tl,br,tr)
   } dgt_job_type;

   typedef enum logic [1:0] {
      PH_VERTEX,
      PH_TRI_A,
      PH_TRI_B
   } dgt_phase_type;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[design/dgt_ram.sv]
// ----------------------------------------------------------------------------
// dgt_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module dgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/dgt_front.sv]
// ----------------------------------------------------------------------------
// dgt_front
// Accepts pixels, tracks position and vertex count, looks up the line
// buffer and classifies each set pixel into a job for the back end.
// ----------------------------------------------------------------------------
module dgt_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [dgt_pkg::SIZE_W-1:0]          cfg_width,
   input  logic [dgt_pkg::SIZE_W-1:0]          cfg_height,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_frame_start,
   input  logic                                req_pixel_set,
   input  logic signed [dgt_pkg::DEPTH_W-1:0]  req_depth_value,
   input  logic [dgt_pkg::GREY_W-1:0]          req_intensity,
   output logic                                push_valid,
   output dgt_pkg::dgt_job_type                push_job,
   input  logic                                queue_full
);

   logic [dgt_pkg::SIZE_W-1:0]     w_eff;
   logic [dgt_pkg::SIZE_W-1:0]     h_eff;
   logic                           restart;
   logic                           accept;
   logic                           col_last;
   logic                           row_last;
   logic [dgt_pkg::COORD_W-1:0]    cur_col;
   logic [dgt_pkg::COORD_W-1:0]    cur_row;
   logic [dgt_pkg::IDX_W-1:0]      cur_vidx;
   logic [dgt_pkg::IDX_W-1:0]      vidx_step;
   logic [dgt_pkg::SIZE_W-1:0]     y_full;

   logic [dgt_pkg::COORD_W-1:0]    col_ff, col_in;
   logic [dgt_pkg::COORD_W-1:0]    row_ff, row_in;
   logic [dgt_pkg::IDX_W-1:0]      vcnt_ff, vcnt_in;

   logic                           clearing_ff, clearing_in;
   logic [dgt_pkg::RAM_ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic                           s1_valid_ff, s1_valid_in;
   logic [dgt_pkg::COORD_W-1:0]    s1_col_ff;
   logic [dgt_pkg::COORD_W-1:0]    s1_y_ff;
   logic                           s1_set_ff;
   logic                           s1_inner_ff;
   logic [dgt_pkg::DEPTH_W-1:0]    s1_depth_ff;
   logic [dgt_pkg::GREY_W-1:0]     s1_grey_ff;
   logic [dgt_pkg::IDX_W-1:0]      s1_idx_ff;
   logic                           hit_ff, hit_in;
   dgt_pkg::dgt_entry_type         fwd_ff;

   dgt_pkg::dgt_entry_type         ul_ff, ul_in;
   dgt_pkg::dgt_entry_type         left_ff, left_in;

   dgt_pkg::dgt_entry_type         above;
   dgt_pkg::dgt_entry_type         cur;
   logic [dgt_pkg::ENTRY_W-1:0]    ram_rdata;
   logic                           ram_wr_en;
   logic [dgt_pkg::RAM_ADDR_W-1:0] ram_wr_addr;
   logic [dgt_pkg::ENTRY_W-1:0]    ram_wr_data;
   logic                           s1_leave;
   logic                           any_tri;

   // ---- position and vertex counting ------------------------------------
   always_comb begin
      w_eff   = dgt_pkg::clamp_size(cfg_width, dgt_pkg::MAX_W_SIZE);
      h_eff   = dgt_pkg::clamp_size(cfg_height, dgt_pkg::MAX_H_SIZE);
      restart = req_frame_start || ({1'b0, col_ff} >= w_eff)
                || ({1'b0, row_ff} >= h_eff);
      cur_col  = restart ? '0 : col_ff;
      cur_row  = restart ? '0 : row_ff;
      cur_vidx = restart ? '0 : vcnt_ff;
      col_last = ({1'b0, cur_col} + dgt_pkg::SIZE_W'(1)) >= w_eff;
      row_last = ({1'b0, cur_row} + dgt_pkg::SIZE_W'(1)) >= h_eff;
      vidx_step = req_pixel_set ? cur_vidx + dgt_pkg::IDX_W'(1) : cur_vidx;
      y_full    = h_eff - dgt_pkg::SIZE_W'(1) - {1'b0, cur_row};

      col_in  = col_ff;
      row_in  = row_ff;
      vcnt_in = vcnt_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : cur_row + dgt_pkg::COORD_W'(1);
         end else begin
            col_in = cur_col + dgt_pkg::COORD_W'(1);
            row_in = cur_row;
         end
         vcnt_in = (col_last && row_last) ? '0 : vidx_step;
      end
   end

   // ---- stage 1: line buffer data arrives, classify --------------------
   always_comb begin
      above    = hit_ff ? fwd_ff : dgt_pkg::dgt_entry_type'(ram_rdata);
      cur      = '{valid: s1_set_ff, index: s1_idx_ff};
      s1_leave = s1_valid_ff && (!s1_set_ff || !queue_full);
      accept   = req_valid && !req_stall;
      any_tri  = s1_inner_ff && ul_ff.valid;

      req_stall = clearing_ff || (s1_valid_ff && !s1_leave);

      s1_valid_in = accept ? 1'b1 : (s1_leave ? 1'b0 : s1_valid_ff);
      // the word leaving now writes the address that the new word reads;
      // hold the choice while the new word waits in stage 1
      hit_in      = accept ? (s1_leave && (s1_col_ff == cur_col)) : hit_ff;

      ul_in   = s1_leave ? above : ul_ff;
      left_in = s1_leave ? cur : left_ff;

      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + dgt_pkg::RAM_ADDR_W'(1);
         if (clr_addr_ff == dgt_pkg::RAM_ADDR_W'(dgt_pkg::MAX_WIDTH - 1)) begin
            clearing_in = 1'b0;
         end
      end

      ram_wr_en   = clearing_ff || s1_leave;
      ram_wr_addr = clearing_ff ? clr_addr_ff : s1_col_ff;
      ram_wr_data = clearing_ff ? '0 : cur;

      push_valid         = s1_valid_ff && s1_set_ff && !queue_full;
      push_job.x         = s1_col_ff;
      push_job.y         = s1_y_ff;
      push_job.z         = s1_depth_ff;
      push_job.grey      = s1_grey_ff;
      push_job.cur_idx   = s1_idx_ff;
      push_job.ul_idx    = ul_ff.index;
      push_job.left_idx  = left_ff.index;
      push_job.above_idx = above.index;
      push_job.tri_a     = any_tri && left_ff.valid;
      push_job.tri_b     = any_tri && above.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         vcnt_ff     <= '0;
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
         ul_ff       <= '0;
         left_ff     <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         vcnt_ff     <= vcnt_in;
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= s1_valid_in;
         hit_ff      <= hit_in;
         ul_ff       <= ul_in;
         left_ff     <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= cur_col;
         s1_y_ff     <= y_full[dgt_pkg::COORD_W-1:0];
         s1_set_ff   <= req_pixel_set;
         s1_inner_ff <= (cur_col != '0) && (cur_row != '0);
         s1_depth_ff <= req_depth_value;
         s1_grey_ff  <= req_intensity;
         s1_idx_ff   <= cur_vidx;
         fwd_ff      <= cur;
      end
   end

   dgt_ram #(
      .WIDTH (dgt_pkg::ENTRY_W),
      .DEPTH (dgt_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (ram_rdata)
   );

endmodule

[design/dgt_queue.sv]
// ----------------------------------------------------------------------------
// dgt_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module dgt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  dgt_pkg::dgt_job_type push_job,
   output logic                 full,
   output logic                 head_valid,
   output dgt_pkg::dgt_job_type head_job,
   input  logic                 pop
);

   dgt_pkg::dgt_job_type          slot_ff [dgt_pkg::QUEUE_DEPTH];
   logic [dgt_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dgt_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dgt_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                          do_pop;

   always_comb begin
      full       = count_ff == dgt_pkg::QCNT_W'(dgt_pkg::QUEUE_DEPTH);
      head_valid = count_ff != '0;
      head_job   = slot_ff[rd_ptr_ff];
      do_pop     = pop && head_valid;
      wr_ptr_in  = push_valid ? wr_ptr_ff + dgt_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + dgt_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + dgt_pkg::QCNT_W'(1);
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - dgt_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/dgt_back.sv]
// ----------------------------------------------------------------------------
// dgt_back
// Walks each job through vertex and triangle results, one per cycle while
// the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module dgt_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 head_valid,
   input  dgt_pkg::dgt_job_type                 head_job,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_item_kind,
   output logic [dgt_pkg::COORD_W-1:0]          rsp_vertex_x,
   output logic [dgt_pkg::COORD_W-1:0]          rsp_vertex_y,
   output logic signed [dgt_pkg::DEPTH_W-1:0]   rsp_vertex_z,
   output logic [dgt_pkg::GREY_W-1:0]           rsp_vertex_grey,
   output logic [dgt_pkg::IDX_W-1:0]            rsp_corner_one,
   output logic [dgt_pkg::IDX_W-1:0]            rsp_corner_two,
   output logic [dgt_pkg::IDX_W-1:0]            rsp_corner_three,
   output logic                                 rsp_last_of_run
);

   dgt_pkg::dgt_phase_type        phase_ff, phase_in;
   logic                          valid_ff, valid_in;
   logic                          load;
   logic                          emit;
   logic                          done;

   logic                          kind_ff, kind_in;
   logic [dgt_pkg::COORD_W-1:0]   x_ff, x_in;
   logic [dgt_pkg::COORD_W-1:0]   y_ff, y_in;
   logic [dgt_pkg::DEPTH_W-1:0]   z_ff, z_in;
   logic [dgt_pkg::GREY_W-1:0]    grey_ff, grey_in;
   logic [dgt_pkg::IDX_W-1:0]     c1_ff, c1_in;
   logic [dgt_pkg::IDX_W-1:0]     c2_ff, c2_in;
   logic [dgt_pkg::IDX_W-1:0]     c3_ff, c3_in;
   logic                          last_ff, last_in;

   always_comb begin
      load = !valid_ff || !rsp_stall;
      emit = load && head_valid;

      kind_in = dgt_pkg::ITEM_VERTEX;
      x_in    = '0;
      y_in    = '0;
      z_in    = '0;
      grey_in = '0;
      c1_in   = '0;
      c2_in   = '0;
      c3_in   = '0;
      done    = 1'b1;
      phase_in = phase_ff;

      case (phase_ff)
         dgt_pkg::PH_VERTEX: begin
            kind_in = dgt_pkg::ITEM_VERTEX;
            x_in    = head_job.x;
            y_in    = head_job.y;
            z_in    = head_job.z;
            grey_in = head_job.grey;
            done    = !head_job.tri_a && !head_job.tri_b;
            if (emit) begin
               if (head_job.tri_a) begin
                  phase_in = dgt_pkg::PH_TRI_A;
               end else if (head_job.tri_b) begin
                  phase_in = dgt_pkg::PH_TRI_B;
               end
            end
         end
         dgt_pkg::PH_TRI_A: begin
            kind_in = dgt_pkg::ITEM_TRIANGLE;
            c1_in   = head_job.ul_idx;
            c2_in   = head_job.left_idx;
            c3_in   = head_job.cur_idx;
            done    = !head_job.tri_b;
            if (emit) begin
               phase_in = head_job.tri_b ? dgt_pkg::PH_TRI_B : dgt_pkg::PH_VERTEX;
            end
         end
         dgt_pkg::PH_TRI_B: begin
            kind_in = dgt_pkg::ITEM_TRIANGLE;
            c1_in   = head_job.ul_idx;
            c2_in   = head_job.cur_idx;
            c3_in   = head_job.above_idx;
            done    = 1'b1;
            if (emit) begin
               phase_in = dgt_pkg::PH_VERTEX;
            end
         end
         default: begin
            phase_in = dgt_pkg::PH_VERTEX;
         end
      endcase

      // return to the vertex phase once the job is finished
      if (emit && done) begin
         phase_in = dgt_pkg::PH_VERTEX;
      end
      last_in  = done;
      pop      = emit && done;
      valid_in = load ? head_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dgt_pkg::PH_VERTEX;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         grey_ff <= grey_in;
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         c3_ff   <= c3_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_item_kind    = kind_ff;
   assign rsp_vertex_x     = x_ff;
   assign rsp_vertex_y     = y_ff;
   assign rsp_vertex_z     = z_ff;
   assign rsp_vertex_grey  = grey_ff;
   assign rsp_corner_one   = c1_ff;
   assign rsp_corner_two   = c2_ff;
   assign rsp_corner_three = c3_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

[design/depth_grid_triangulator.sv]
// ----------------------------------------------------------------------------
// depth_grid_triangulator
// Turns a raster stream of depth pixels into interleaved mesh vertices and
// triangles, using a one-row line buffer of flags and vertex indices.
// ----------------------------------------------------------------------------
//  Channel   Ports                           Direction  Moves
//  req       req_valid / req_stall + fields  in         one pixel word
//  rsp       rsp_valid / rsp_stall + fields  out        one vertex or triangle word
//  csr       csr_wr_en, csr_index, csr_data  in         frame width / height write
//
//  A pixel word is taken every cycle while the job queue has room; the back
//  end then turns it into a vertex and up to two triangles, so fully
//  populated interior pixels can fill the queue and raise req_stall.
//  Unset pixels give no results and cost the back end nothing.
//  After reset all 1024 line buffer RAM entries are swept clear, during
//  which req_stall stays high. Stall on rsp backs up through the queue to
//  req_stall; the output register holds its word while stalled.
// ----------------------------------------------------------------------------
module depth_grid_triangulator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [dgt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dgt_pkg::SIZE_W-1:0]           csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_frame_start,
   input  logic                                 req_pixel_set,
   input  logic signed [dgt_pkg::DEPTH_W-1:0]   req_depth_value,
   input  logic [dgt_pkg::GREY_W-1:0]           req_intensity,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_item_kind,
   output logic [dgt_pkg::COORD_W-1:0]          rsp_vertex_x,
   output logic [dgt_pkg::COORD_W-1:0]          rsp_vertex_y,
   output logic signed [dgt_pkg::DEPTH_W-1:0]   rsp_vertex_z,
   output logic [dgt_pkg::GREY_W-1:0]           rsp_vertex_grey,
   output logic [dgt_pkg::IDX_W-1:0]            rsp_corner_one,
   output logic [dgt_pkg::IDX_W-1:0]            rsp_corner_two,
   output logic [dgt_pkg::IDX_W-1:0]            rsp_corner_three,
   output logic                                 rsp_last_of_run
);

   logic [dgt_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [dgt_pkg::SIZE_W-1:0] height_ff, height_in;

   logic                       push_valid;
   dgt_pkg::dgt_job_type       push_job;
   logic                       queue_full;
   logic                       head_valid;
   dgt_pkg::dgt_job_type       head_job;
   logic                       pop;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            dgt_pkg::CSR_FRAME_WIDTH: begin
               width_in = csr_data;
            end
            dgt_pkg::CSR_FRAME_HEIGHT: begin
               height_in = csr_data;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dgt_pkg::RESET_WIDTH;
         height_ff <= dgt_pkg::RESET_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   dgt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg_width       (width_ff),
      .cfg_height      (height_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_frame_start (req_frame_start),
      .req_pixel_set   (req_pixel_set),
      .req_depth_value (req_depth_value),
      .req_intensity   (req_intensity),
      .push_valid      (push_valid),
      .push_job        (push_job),
      .queue_full      (queue_full)
   );

   dgt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   dgt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_vertex_z     (rsp_vertex_z),
      .rsp_vertex_grey  (rsp_vertex_grey),
      .rsp_corner_one   (rsp_corner_one),
      .rsp_corner_two   (rsp_corner_two),
      .rsp_corner_three (rsp_corner_three),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth grid triangulator. Pixel words are
// driven in raster order while a local mesh predictor tracks the vertex
// counter and the line buffer and queues the vertex and triangle words each
// pixel should produce. A monitor compares every accepted result word field
// by field with the oldest queued word. Directed tests cover reset sizes,
// depth and size extremes, end-of-frame wrap and resizing inside a frame.
// Randomized frames, mostly well formed, then run under three idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
   import dgt_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 16;

   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] vx;
      logic [COORD_W-1:0] vy;
      logic [DEPTH_W-1:0] vz;
      logic [GREY_W-1:0]  grey;
      logic [IDX_W-1:0]   corner_a;
      logic [IDX_W-1:0]   corner_b;
      logic [IDX_W-1:0]   corner_c;
      logic               last;
   } mesh_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index = CSR_FRAME_WIDTH;
   logic [SIZE_W-1:0]           csr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_frame_start = 1'b0;
   logic                        req_pixel_set = 1'b0;
   logic signed [DEPTH_W-1:0]   req_depth_value = '0;
   logic [GREY_W-1:0]           req_intensity = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_item_kind;
   logic [COORD_W-1:0]          rsp_vertex_x;
   logic [COORD_W-1:0]          rsp_vertex_y;
   logic signed [DEPTH_W-1:0]   rsp_vertex_z;
   logic [GREY_W-1:0]           rsp_vertex_grey;
   logic [IDX_W-1:0]            rsp_corner_one;
   logic [IDX_W-1:0]            rsp_corner_two;
   logic [IDX_W-1:0]            rsp_corner_three;
   logic                        rsp_last_of_run;

   // mesh predictor state
   logic [SIZE_W-1:0]  cfg_width;
   logic [SIZE_W-1:0]  cfg_height;
   int unsigned        col_pos;
   int unsigned        row_pos;
   logic [IDX_W-1:0]   next_vertex;
   dgt_entry_type      line_buf [MAX_WIDTH];
   dgt_entry_type      diag_nb;
   dgt_entry_type      left_nb;

   mesh_word_type      mesh_words_due [$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 send_gap_pct = 0;
   int                 stall_pct = 0;
   int                 set_pixels_sent = 0;

   depth_grid_triangulator i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_start  (req_frame_start),
      .req_pixel_set    (req_pixel_set),
      .req_depth_value  (req_depth_value),
      .req_intensity    (req_intensity),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_vertex_z     (rsp_vertex_z),
      .rsp_vertex_grey  (rsp_vertex_grey),
      .rsp_corner_one   (rsp_corner_one),
      .rsp_corner_two   (rsp_corner_two),
      .rsp_corner_three (rsp_corner_three),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int unsigned fit_size(input logic [SIZE_W-1:0] v,
                                            input int unsigned top);
      if (v == '0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic mesh_word_type make_word(input logic kind,
                                               input logic [COORD_W-1:0] vx,
                                               input logic [COORD_W-1:0] vy,
                                               input logic [DEPTH_W-1:0] vz,
                                               input logic [GREY_W-1:0] grey,
                                               input logic [IDX_W-1:0] ca,
                                               input logic [IDX_W-1:0] cb,
                                               input logic [IDX_W-1:0] cc,
                                               input logic last);
      mesh_word_type wd;
      wd.kind     = kind;
      wd.vx       = vx;
      wd.vy       = vy;
      wd.vz       = vz;
      wd.grey     = grey;
      wd.corner_a = ca;
      wd.corner_b = cb;
      wd.corner_c = cc;
      wd.last     = last;
      return wd;
   endfunction

   // Queue the vertex and triangle words one accepted pixel produces.
   task automatic predict_mesh_words(input logic fs, input logic ps,
                                     input logic [DEPTH_W-1:0] depth,
                                     input logic [GREY_W-1:0] grey);
      int unsigned   w;
      int unsigned   h;
      int unsigned   c;
      int unsigned   r;
      int            n;
      logic          tri_a;
      logic          tri_b;
      dgt_entry_type up;
      dgt_entry_type here;
      w = fit_size(cfg_width, MAX_WIDTH);
      h = fit_size(cfg_height, MAX_HEIGHT);
      if (fs || col_pos >= w || row_pos >= h) begin
         col_pos     = 0;
         row_pos     = 0;
         next_vertex = '0;
      end
      c = col_pos;
      r = row_pos;
      up = line_buf[c];
      here.valid = ps;
      here.index = next_vertex;
      tri_a = ps && r >= 1 && c >= 1 && diag_nb.valid && left_nb.valid;
      tri_b = ps && r >= 1 && c >= 1 && diag_nb.valid && up.valid;
      n = int'(ps) + int'(tri_a) + int'(tri_b);
      if (ps) begin
         mesh_words_due.push_back(make_word(ITEM_VERTEX, COORD_W'(c), COORD_W'(h - 1 - r),
                                            depth, grey, '0, '0, '0, n == 1));
         next_vertex = next_vertex + 1'b1;
         if (tri_a) begin
            mesh_words_due.push_back(make_word(ITEM_TRIANGLE, '0, '0, '0, '0, diag_nb.index,
                                               left_nb.index, here.index, !tri_b));
         end
         if (tri_b) begin
            mesh_words_due.push_back(make_word(ITEM_TRIANGLE, '0, '0, '0, '0, diag_nb.index,
                                               here.index, up.index, 1'b1));
         end
      end
      diag_nb     = up;
      line_buf[c] = here;
      left_nb     = here;
      if (c + 1 >= w) begin
         col_pos = 0;
         if (r + 1 >= h) begin
            row_pos     = 0;
            next_vertex = '0;
         end else begin
            row_pos = r + 1;
         end
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                  input logic [31:0] want_v);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got_v,
               want_v);
      mismatch_count++;
   endtask

   task automatic check_word(input mesh_word_type got);
      mesh_word_type want;
      if (mesh_words_due.size() == 0) begin
         report_mismatch("unexpected word, kind", got.kind, '0);
      end else begin
         want = mesh_words_due.pop_front();
         if (got.kind !== want.kind) report_mismatch("item_kind", got.kind, want.kind);
         if (got.vx !== want.vx) report_mismatch("vertex_x", got.vx, want.vx);
         if (got.vy !== want.vy) report_mismatch("vertex_y", got.vy, want.vy);
         if (got.vz !== want.vz) report_mismatch("vertex_z", got.vz, want.vz);
         if (got.grey !== want.grey) report_mismatch("vertex_grey", got.grey, want.grey);
         if (got.corner_a !== want.corner_a)
            report_mismatch("corner_one", got.corner_a, want.corner_a);
         if (got.corner_b !== want.corner_b)
            report_mismatch("corner_two", got.corner_b, want.corner_b);
         if (got.corner_c !== want.corner_c)
            report_mismatch("corner_three", got.corner_c, want.corner_c);
         if (got.last !== want.last) report_mismatch("last_of_run", got.last, want.last);
      end
   endtask

   // result monitor and random stall on the result side
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_word(make_word(rsp_item_kind, rsp_vertex_x, rsp_vertex_y, rsp_vertex_z,
                                 rsp_vertex_grey, rsp_corner_one, rsp_corner_two,
                                 rsp_corner_three, rsp_last_of_run));
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_pixel(input logic fs, input logic ps, input logic [DEPTH_W-1:0] depth,
                             input logic [GREY_W-1:0] grey);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid       <= 1'b1;
      req_frame_start <= fs;
      req_pixel_set   <= ps;
      req_depth_value <= depth;
      req_intensity   <= grey;
      do @(posedge clock); while (req_stall);
      predict_mesh_words(fs, ps, depth, grey);
      if (ps) set_pixels_sent++;
   endtask

   // Drop valid, then wait for every queued word plus the pipeline tail.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mesh_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) cfg_width = val;
      else cfg_height = val;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
   endtask

   // Reset sizes 640x480: y flips against 479; depth and grey extremes.
   task automatic test_reset_sizes();
      send_pixel(1'b0, 1'b1, 32'h8000_0000, 8'h00);
      send_pixel(1'b0, 1'b0, 32'h7FFF_FFFF, 8'hFF);
      send_pixel(1'b0, 1'b1, 32'h7FFF_FFFF, 8'hFF);
   endtask

   // Full 3x3 frame, then one pixel past the end to check the wrap.
   task automatic test_small_grid();
      int k;
      set_frame(11'd3, 11'd3);
      for (k = 0; k < 9; k++) send_pixel(k == 0, 1'b1, $urandom, 8'($urandom));
      send_pixel(1'b0, 1'b1, 32'h0000_0000, 8'h5A);
   endtask

   // Zero sizes act as one: every pixel is its own frame.
   task automatic test_zero_sizes();
      set_frame(11'd0, 11'd0);
      send_pixel(1'b0, 1'b1, 32'hFFFF_FFFF, 8'hA5);
      send_pixel(1'b1, 1'b1, 32'h0001_0000, 8'h3C);
   endtask

   // Shrink width, then height, while the position sits past the new edge.
   task automatic test_resize_mid_frame();
      int k;
      set_frame(11'd3, 11'd3);
      for (k = 0; k < 3; k++) send_pixel(k == 0, 1'b1, $urandom, 8'($urandom));
      send_pixel(1'b0, 1'b1, $urandom, 8'($urandom));
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, 11'd1);
      send_pixel(1'b0, 1'b1, $urandom, 8'($urandom));
      set_frame(11'd2, 11'd3);
      for (k = 0; k < 4; k++) send_pixel(k == 0, 1'b1, $urandom, 8'($urandom));
      drain_pipeline();
      write_reg(CSR_FRAME_HEIGHT, 11'd2);
      send_pixel(1'b0, 1'b1, $urandom, 8'($urandom));
   endtask

   // Oversized registers clamp to 1024: y flips against 1023.
   task automatic test_wide_frame();
      int k;
      set_frame(11'd1024, 11'd2047);
      for (k = 0; k < 4; k++) send_pixel(k == 0, k != 2, $urandom, 8'($urandom));
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, 11'd2047);
      send_pixel(1'b1, 1'b1, $urandom, 8'($urandom));
      send_pixel(1'b0, 1'b1, $urandom, 8'($urandom));
   endtask

   // One frame with random sizes and content; some frames are cut or spill over.
   task automatic send_random_frame();
      logic [SIZE_W-1:0]  wr_w;
      logic [SIZE_W-1:0]  wr_h;
      logic [DEPTH_W-1:0] depth;
      int                 n;
      int                 k;
      logic               fs;
      logic               ps;
      wr_w = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(1024, 2047))
                                      : SIZE_W'($urandom_range(0, 8));
      wr_h = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(1024, 2047))
                                      : SIZE_W'($urandom_range(0, 6));
      set_frame(wr_w, wr_h);
      n = fit_size(wr_w, MAX_WIDTH) * fit_size(wr_h, MAX_HEIGHT);
      if (n > 48) n = $urandom_range(4, 24);
      if ($urandom_range(4) == 0) n = $urandom_range(1, n + 3);
      for (k = 0; k < n; k++) begin
         fs = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
         ps = ($urandom_range(99) < 80);
         case ($urandom_range(7))
            0: depth = 32'h8000_0000;
            1: depth = 32'h7FFF_FFFF;
            2: depth = 32'hFFFF_FFFF;
            default: depth = $urandom;
         endcase
         send_pixel(fs, ps, depth, 8'($urandom));
      end
   endtask

   task automatic test_random_frames(input int gap_pct, input int hold_pct, input int goal);
      int start;
      send_gap_pct = gap_pct;
      stall_pct    = hold_pct;
      start        = set_pixels_sent;
      while (set_pixels_sent - start < goal) send_random_frame();
   endtask

   initial begin
      cfg_width   = RESET_WIDTH;
      cfg_height  = RESET_HEIGHT;
      col_pos     = 0;
      row_pos     = 0;
      next_vertex = '0;
      diag_nb     = '0;
      left_nb     = '0;
      foreach (line_buf[i]) line_buf[i] = '0;
      send_gap_pct = 24;
      stall_pct    = 74;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_sizes();
      test_small_grid();
      test_zero_sizes();
      test_resize_mid_frame();
      test_wide_frame();
      test_random_frames(24, 74, 25);
      test_random_frames(74, 24, 25);
      test_random_frames(0, 0, 25);

      drain_pipeline();
      if (mismatch_count == 0 && mesh_words_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
